// ===== hdl/bhfc_pkg.sv =====
// bhfc_pkg.sv: shared types, codes and tables of the bmp header format classifier
`timescale 1ns / 1ps
package bhfc_pkg;

	localparam int POS_W = 17;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [7:0] SIG_B = 8'd66;
	localparam logic [7:0] SIG_M = 8'd77;

	localparam logic [15:0] DEPTH_1  = 16'd1;
	localparam logic [15:0] DEPTH_4  = 16'd4;
	localparam logic [15:0] DEPTH_8  = 16'd8;
	localparam logic [15:0] DEPTH_16 = 16'd16;

	localparam logic [31:0] COMP_RGB      = 32'd0;
	localparam logic [31:0] COMP_BITFIELD = 32'd3;

	localparam logic [15:0] MIN_HDR_SIZE = 16'd20;
	localparam logic [16:0] FILE_HDR_LEN = 17'd14;

	localparam logic [2:0] FMT_GRAY256  = 3'd0;
	localparam logic [2:0] FMT_RGB332   = 3'd1;
	localparam logic [2:0] FMT_GRAY16   = 3'd2;
	localparam logic [2:0] FMT_CLUT16   = 3'd3;
	localparam logic [2:0] FMT_MONO     = 3'd4;
	localparam logic [2:0] FMT_ARGB4444 = 3'd5;
	localparam logic [2:0] FMT_RGB565LE = 3'd6;

	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_SIGNATURE = 3'd1;
	localparam logic [2:0] ERR_COMPRESS  = 3'd2;
	localparam logic [2:0] ERR_WIDTH     = 3'd3;
	localparam logic [2:0] ERR_PALETTE   = 3'd4;
	localparam logic [2:0] ERR_DEPTH     = 3'd5;
	localparam logic [2:0] ERR_TRUNC     = 3'd6;
	localparam logic [2:0] ERR_HDR_SIZE  = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
		logic       end_of_file;
	} item_t;

	typedef struct packed {
		logic [2:0]  pixel_format;
		logic [2:0]  error_code;
		logic [31:0] image_width;
		logic [31:0] image_height;
		logic [31:0] pixel_offset;
	} result_t;

	// little-endian argb4444 channel masks: 0x0f00, 0x00f0, 0x000f, 0xf000
	function automatic logic [7:0] mask_byte(input logic [3:0] idx);
		logic [7:0] v;
		case (idx)
			4'd1:    v = 8'h0f;
			4'd4:    v = 8'hf0;
			4'd8:    v = 8'h0f;
			4'd13:   v = 8'hf0;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/bmp_header_format_classifier_core.sv =====
// bmp_header_format_classifier_core.sv: top level with input and result registers
`timescale 1ns / 1ps
// Classifies a BMP file streamed one byte per transaction on the item channel.
// item carries the byte plus start_of_file (restarts the parse at this byte)
// and end_of_file (last byte; an undecided header then reports truncation).
// A transaction on either channel completes at a rising edge with valid high
// and stall low.
// At most one result per file leaves on the result channel, at the byte that
// settles the decision (signature, header check at byte 33, end of palette or
// of the 16-bit channel masks, or truncation); later bytes give nothing until
// the next start_of_file.
// Throughput: one byte per cycle while the result channel is not stalled. An
// accepted byte lands in the input register, is classified as it passes on
// into the result register, and its result is valid once it is there.
// The input register drains into the result register whenever that register
// is empty or being taken, so a stalled result blocks input only once the
// input register also holds a byte.
// arst_n empties both registers and clears all parse state; parsing then
// expects a signature at the next byte.
module bmp_header_format_classifier_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  bhfc_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output bhfc_pkg::result_t result
);
	import bhfc_pkg::*;

	logic      valid_s1;
	item_t     item_s1;
	logic      result_valid_q;
	result_t   result_q;
	logic      advance;
	logic      hit;
	result_t   res;

	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall   = valid_s1 && !advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	bhfc_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.hit    (hit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= hit;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			result_q <= res;
		end
	end

	// an empty input register never holds off the sender
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !item_stall)
		else $error("item stalled with empty input register");

	// a stalled result keeps the pending byte in the input register
	a_hold_s1_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && result_valid_q && result_stall |=> valid_s1)
		else $error("input register drained while result stalled");

	// error results always report the default format code
	a_err_fmt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.error_code == ERR_OK ||
			result_q.pixel_format == FMT_GRAY256))
		else $error("error result with nonzero pixel format");

	// height magnitude never exceeds two to the thirty-first
	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> result_q.image_height <= 32'h8000_0000)
		else $error("image height out of range");

endmodule

// ===== hdl/bhfc_parser.sv =====
// bhfc_parser.sv: header field state and per-byte classification decision
`timescale 1ns / 1ps
module bhfc_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  bhfc_pkg::item_t item,
	output logic            hit,
	output bhfc_pkg::result_t res
);
	import bhfc_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [31:0]      offset_q;
	logic [15:0]      hdr_size_q;
	logic [31:0]      width_q;
	logic [31:0]      height_q;
	logic [15:0]      depth_q;
	logic [31:0]      comp_q;
	logic             gray8_q;
	logic             gray4_q;
	logic             mask_q;
	logic             decided_q;

	logic [POS_W-1:0] pos_c, pos_n;
	logic [31:0]      offset_c, offset_n;
	logic [15:0]      hdr_size_c, hdr_size_n;
	logic [31:0]      width_c, width_n;
	logic [31:0]      height_c, height_n;
	logic [15:0]      depth_c, depth_n;
	logic [31:0]      comp_c, comp_n;
	logic             gray8_c, gray8_n;
	logic             gray4_c, gray4_n;
	logic             mask_c, mask_n;
	logic             decided_c, decided_n;

	logic [7:0]       b;
	logic [31:0]      b32;
	logic [16:0]      p0;
	logic [16:0]      rel;
	logic [POS_W-1:0] lane_full;
	logic [3:0]       e4;
	logic [2:0]       fmt;
	logic [2:0]       err;

	assign b   = item.data_byte;
	assign b32 = {24'd0, b};
	assign p0  = {1'b0, hdr_size_c} + FILE_HDR_LEN;
	assign rel = pos_c - p0;
	assign e4  = rel[5:2];

	always_comb begin
		// start of file behaves as a reset of the parse
		if (item.start_of_file) begin
			pos_c      = '0;
			offset_c   = '0;
			hdr_size_c = '0;
			width_c    = '0;
			height_c   = '0;
			depth_c    = '0;
			comp_c     = '0;
			gray8_c    = 1'b1;
			gray4_c    = 1'b1;
			mask_c     = 1'b1;
			decided_c  = 1'b0;
		end else begin
			pos_c      = pos_q;
			offset_c   = offset_q;
			hdr_size_c = hdr_size_q;
			width_c    = width_q;
			height_c   = height_q;
			depth_c    = depth_q;
			comp_c     = comp_q;
			gray8_c    = gray8_q;
			gray4_c    = gray4_q;
			mask_c     = mask_q;
			decided_c  = decided_q;
		end
	end

	always_comb begin
		pos_n      = pos_c;
		offset_n   = offset_c;
		hdr_size_n = hdr_size_c;
		width_n    = width_c;
		height_n   = height_c;
		depth_n    = depth_c;
		comp_n     = comp_c;
		gray8_n    = gray8_c;
		gray4_n    = gray4_c;
		mask_n     = mask_c;
		decided_n  = decided_c;
		hit        = 1'b0;
		fmt        = FMT_GRAY256;
		err        = ERR_OK;
		lane_full  = '0;
		if (!decided_c) begin
			if (pos_c == 17'd0) begin
				if (b != SIG_B) begin
					hit = 1'b1;
					err = ERR_SIGNATURE;
				end
			end else if (pos_c == 17'd1) begin
				if (b != SIG_M) begin
					hit = 1'b1;
					err = ERR_SIGNATURE;
				end
			end else if (pos_c >= 17'd10 && pos_c <= 17'd13) begin
				lane_full = pos_c - 17'd10;
				offset_n  = offset_c | (b32 << {lane_full[1:0], 3'b000});
			end else if (pos_c >= 17'd14 && pos_c <= 17'd15) begin
				hdr_size_n = hdr_size_c | (16'(b) << {pos_c[0], 3'b000});
			end else if (pos_c >= 17'd18 && pos_c <= 17'd21) begin
				lane_full = pos_c - 17'd18;
				width_n   = width_c | (b32 << {lane_full[1:0], 3'b000});
			end else if (pos_c >= 17'd22 && pos_c <= 17'd25) begin
				lane_full = pos_c - 17'd22;
				height_n  = height_c | (b32 << {lane_full[1:0], 3'b000});
				// negative height is stored as its magnitude
				if (pos_c == 17'd25 && b[7]) begin
					height_n = (~height_n) + 32'd1;
				end
			end else if (pos_c >= 17'd28 && pos_c <= 17'd29) begin
				depth_n = depth_c | (16'(b) << {pos_c[0], 3'b000});
			end else if (pos_c >= 17'd30 && pos_c <= 17'd33) begin
				lane_full = pos_c - 17'd30;
				comp_n    = comp_c | (b32 << {lane_full[1:0], 3'b000});
				if (pos_c == 17'd33) begin
					case (depth_c)
						DEPTH_1: begin
							hit = 1'b1;
							if (comp_n != COMP_RGB) err = ERR_COMPRESS;
							else if (width_c[4:0] != 5'd0) err = ERR_WIDTH;
							else fmt = FMT_MONO;
						end
						DEPTH_16: begin
							if (comp_n != COMP_BITFIELD) begin
								hit = 1'b1;
								err = ERR_COMPRESS;
							end else if (width_c[0]) begin
								hit = 1'b1;
								err = ERR_WIDTH;
							end
						end
						DEPTH_8: begin
							if (comp_n != COMP_RGB) begin
								hit = 1'b1;
								err = ERR_COMPRESS;
							end else if (width_c[1:0] != 2'd0) begin
								hit = 1'b1;
								err = ERR_WIDTH;
							end else if (hdr_size_c < MIN_HDR_SIZE) begin
								hit = 1'b1;
								err = ERR_HDR_SIZE;
							end
						end
						DEPTH_4: begin
							if (comp_n != COMP_RGB) begin
								hit = 1'b1;
								err = ERR_COMPRESS;
							end else if (width_c[2:0] != 3'd0) begin
								hit = 1'b1;
								err = ERR_WIDTH;
							end else if (hdr_size_c < MIN_HDR_SIZE) begin
								hit = 1'b1;
								err = ERR_HDR_SIZE;
							end
						end
						default: begin
							hit = 1'b1;
							err = ERR_DEPTH;
						end
					endcase
				end
			end else if (pos_c >= 17'd34) begin
				if (depth_c == DEPTH_16) begin
					if (pos_c >= 17'd54 && pos_c <= 17'd69) begin
						lane_full = pos_c - 17'd54;
						if (b != mask_byte(lane_full[3:0])) mask_n = 1'b0;
						if (pos_c == 17'd69) begin
							hit = 1'b1;
							fmt = mask_n ? FMT_ARGB4444 : FMT_RGB565LE;
						end
					end
				end else if (depth_c == DEPTH_8 && pos_c >= p0) begin
					if (rel < 17'd1024) begin
						if (rel[1:0] != 2'd3 && b != rel[9:2]) gray8_n = 1'b0;
						if (rel == 17'd1023) begin
							hit = 1'b1;
							fmt = gray8_n ? FMT_GRAY256 : FMT_RGB332;
						end
					end
				end else if (depth_c == DEPTH_4 && pos_c >= p0) begin
					if (rel < 17'd64) begin
						if (rel[1:0] != 2'd3 && b != {e4, e4}) gray4_n = 1'b0;
						if (rel == 17'd63) begin
							hit = 1'b1;
							// non-gray palette is usable only when pixels follow it
							if (gray4_n) fmt = FMT_GRAY16;
							else if (offset_c != {15'd0, p0} + 32'd64) err = ERR_PALETTE;
							else fmt = FMT_CLUT16;
						end
					end
				end
			end
			if (pos_c != POS_MAX) pos_n = pos_c + 17'd1;
			if (!hit && item.end_of_file) begin
				hit = 1'b1;
				err = ERR_TRUNC;
			end
			if (hit) decided_n = 1'b1;
		end
	end

	always_comb begin
		res.pixel_format = fmt;
		res.error_code   = err;
		res.image_width  = width_n;
		res.image_height = height_n;
		res.pixel_offset = offset_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			offset_q   <= '0;
			hdr_size_q <= '0;
			width_q    <= '0;
			height_q   <= '0;
			depth_q    <= '0;
			comp_q     <= '0;
			gray8_q    <= 1'b1;
			gray4_q    <= 1'b1;
			mask_q     <= 1'b1;
			decided_q  <= 1'b0;
		end else if (step) begin
			pos_q      <= pos_n;
			offset_q   <= offset_n;
			hdr_size_q <= hdr_size_n;
			width_q    <= width_n;
			height_q   <= height_n;
			depth_q    <= depth_n;
			comp_q     <= comp_n;
			gray8_q    <= gray8_n;
			gray4_q    <= gray4_n;
			mask_q     <= mask_n;
			decided_q  <= decided_n;
		end
	end

endmodule
